@@ src/saes_pkg.sv @@
// shared types and constants of the servo axis enable sequencer
package saes_pkg;

    localparam int NUM_AXES_DEF     = 7;
    localparam int RETRY_PERIOD_DEF = 5;

    localparam int IDX_W    = 3;
    localparam int STATUS_W = 16;
    localparam int POS_W    = 32;
    localparam int STEP_W   = 16;

    // drive states seen in the status low byte
    localparam logic [7:0] ST_SWITCH_ON_DISABLED = 8'h50;
    localparam logic [7:0] ST_READY_TO_SWITCH_ON = 8'h21;
    localparam logic [7:0] ST_READY_ALT          = 8'h31;
    localparam logic [7:0] ST_SWITCHED_ON        = 8'h33;
    localparam logic [7:0] ST_OP_ENABLED         = 8'h37;

    // control words
    localparam logic [STATUS_W-1:0] CW_SHUTDOWN  = 16'h0006;
    localparam logic [STATUS_W-1:0] CW_SWITCH_ON = 16'h0007;
    localparam logic [STATUS_W-1:0] CW_ENABLE_OP = 16'h000F;

    // register reset values
    localparam logic [POS_W-1:0]  DEFAULT_POSITION_RST   = 32'd0;
    localparam logic [STEP_W-1:0] APPROACH_STEP_RST      = 16'd120;
    localparam logic [STEP_W-1:0] APPROACH_TOLERANCE_RST = 16'd80;

    typedef enum logic [1:0] {
        CFG_DEFAULT_POSITION   = 2'd0,
        CFG_APPROACH_STEP      = 2'd1,
        CFG_APPROACH_TOLERANCE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [STATUS_W-1:0] control_word;
        logic                control_valid;
        logic [POS_W-1:0]    target_pos;
        logic                target_valid;
        logic                axis_enabled;
        logic                all_enabled;
        logic                homing_done;
    } result_t;

    typedef struct packed {
        logic [POS_W-1:0]  hi_thr;
        logic [POS_W-1:0]  lo_thr;
        logic [STEP_W-1:0] approach_step;
    } approach_cfg_t;

endpackage

@@ src/saes_axis_core.sv @@
// per-axis state and the combinational enable and homing step
module saes_axis_core
    import saes_pkg::*;
#(
    parameter int NUM_AXES     = NUM_AXES_DEF,
    parameter int RETRY_PERIOD = RETRY_PERIOD_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [IDX_W-1:0]    axis_index,
    input  logic [STATUS_W-1:0] drive_status,
    input  logic [POS_W-1:0]    actual_position,
    input  logic                last_axis,
    input  approach_cfg_t       acfg,
    output result_t             res,
    output logic                all_on
);

    localparam int RETRY_W = $clog2(RETRY_PERIOD + 1);
    localparam int SEL_W   = IDX_W + 2;
    localparam logic [RETRY_W-1:0] RETRY_RELOAD = RETRY_W'(RETRY_PERIOD);

    logic [STATUS_W-1:0] prev_reg   [NUM_AXES];
    logic [RETRY_W-1:0]  retry_reg  [NUM_AXES];
    logic [POS_W-1:0]    target_reg [NUM_AXES];
    logic [NUM_AXES-1:0] homed_reg;
    logic [NUM_AXES-1:0] on_reg;
    logic                all_on_reg;

    logic [NUM_AXES-1:0] sel;
    logic                in_range;
    logic [7:0]          low;
    logic [STATUS_W-1:0] prev_rd;
    logic [RETRY_W-1:0]  retry_rd;
    logic [POS_W-1:0]    target_rd;
    logic                homed_rd;
    logic [RETRY_W-1:0]  retry_eff;
    logic [RETRY_W-1:0]  retry_next;
    logic [POS_W-1:0]    target_next;
    logic                homed_next;
    logic [NUM_AXES-1:0] on_next;
    logic                all_on_next;
    logic                is_enabled;
    logic                capture;
    logic                fire;
    logic [POS_W-1:0]    target_dn;
    logic [POS_W-1:0]    target_up;

    always_comb
    begin
        sel       = '0;
        prev_rd   = '0;
        retry_rd  = '0;
        target_rd = '0;
        homed_rd  = 1'b0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            sel[i] = ({2'b00, axis_index} == SEL_W'(i));
            if (sel[i])
            begin
                prev_rd   = prev_reg[i];
                retry_rd  = retry_reg[i];
                target_rd = target_reg[i];
                homed_rd  = homed_reg[i];
            end
        end
    end

    assign in_range   = |sel;
    assign low        = drive_status[7:0];
    assign is_enabled = (low == ST_OP_ENABLED);
    assign retry_eff  = (prev_rd != drive_status) ? RETRY_RELOAD : retry_rd;
    assign fire       = (retry_eff == RETRY_RELOAD);
    assign target_dn  = target_rd - {16'd0, acfg.approach_step};
    assign target_up  = target_rd + {16'd0, acfg.approach_step};

    always_comb
    begin
        res         = '0;
        retry_next  = retry_eff;
        target_next = target_rd;
        homed_next  = homed_rd;
        capture     = 1'b0;
        on_next     = on_reg;
        all_on_next = all_on_reg;
        if (!all_on_reg)
        begin
            if (in_range)
            begin
                on_next = (on_reg & ~sel) | (is_enabled ? sel : '0);
                if (!is_enabled)
                begin
                    if (fire)
                    begin
                        case (low) inside
                            ST_SWITCH_ON_DISABLED:
                            begin
                                res.control_word  = CW_SHUTDOWN;
                                res.control_valid = 1'b1;
                            end
                            ST_READY_TO_SWITCH_ON, ST_READY_ALT:
                            begin
                                res.control_word  = CW_SWITCH_ON;
                                res.control_valid = 1'b1;
                                capture           = 1'b1;
                            end
                            ST_SWITCHED_ON:
                            begin
                                res.control_word  = CW_ENABLE_OP;
                                res.control_valid = 1'b1;
                                capture           = 1'b1;
                            end
                            default:
                            begin
                                res.control_valid = 1'b0;
                            end
                        endcase
                    end
                    retry_next = (retry_eff == '0) ? RETRY_RELOAD : retry_eff - 1'b1;
                end
            end
            if (capture)
            begin
                target_next      = actual_position;
                res.target_pos   = actual_position;
                res.target_valid = 1'b1;
            end
            if (last_axis)
            begin
                all_on_next = &on_next;
            end
        end
        else if (in_range && is_enabled && !homed_rd)
        begin
            if ($signed(actual_position) > $signed(acfg.hi_thr))
            begin
                target_next = target_dn;
            end
            else if ($signed(actual_position) < $signed(acfg.lo_thr))
            begin
                target_next = target_up;
            end
            else
            begin
                homed_next = 1'b1;
            end
            res.target_pos   = target_next;
            res.target_valid = 1'b1;
        end
        res.axis_enabled = in_range && is_enabled;
        res.all_enabled  = all_on_next;
        res.homing_done  = in_range && homed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                prev_reg[i]   <= '0;
                retry_reg[i]  <= RETRY_RELOAD;
                target_reg[i] <= '0;
            end
            homed_reg  <= '0;
            on_reg     <= '0;
            all_on_reg <= 1'b0;
        end
        else if (step)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (sel[i])
                begin
                    prev_reg[i]   <= all_on_reg ? prev_reg[i] : drive_status;
                    retry_reg[i]  <= all_on_reg ? retry_reg[i] : retry_next;
                    target_reg[i] <= target_next;
                    homed_reg[i]  <= homed_next;
                end
            end
            on_reg     <= on_next;
            all_on_reg <= all_on_next;
        end
    end

    assign all_on = all_on_reg;

endmodule

@@ src/servo_axis_enable_sequencer.sv @@
// top level: configuration registers, input register, output register
// Servo axis enable sequencer.
// Input channel: in_valid / in_stall with axis_index, drive_status,
// actual_position and last_axis; a transfer happens when in_valid is high
// and in_stall is low. Output channel: out_valid / out_stall with one result
// per input item, presented in input order.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, index 0 is the home position, 1 the approach
// step, 2 the home tolerance; other indexes are ignored.
// An item taken in lands in the input register; the axis core processes
// it from there and its result is registered in the output register,
// which drives out_valid; a stall can hold the item in the input register.
// Throughput: one item per cycle while out_stall is low; the per-axis
// state is read, updated and written back as the result is registered.
// When the receiver stalls, the output register holds its result and the
// input register holds the next item; in_stall rises only while both are
// full and out_stall is high. Reset empties both registers, puts every axis
// back to its reset state (retry counter reloaded, not homed, not enabled)
// and returns the block to status mode.
module servo_axis_enable_sequencer
    import saes_pkg::*;
#(
    parameter int NUM_AXES     = NUM_AXES_DEF,
    parameter int RETRY_PERIOD = RETRY_PERIOD_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [IDX_W-1:0]    axis_index,
    input  logic [STATUS_W-1:0] drive_status,
    input  logic [POS_W-1:0]    actual_position,
    input  logic                last_axis,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] control_word,
    output logic                control_valid,
    output logic [POS_W-1:0]    target_pos,
    output logic                target_valid,
    output logic                axis_enabled,
    output logic                all_enabled,
    output logic                homing_done,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [POS_W-1:0]    cfg_data
);

    logic [POS_W-1:0]    default_position_reg;
    logic [STEP_W-1:0]   approach_step_reg;
    logic [STEP_W-1:0]   approach_tolerance_reg;
    logic [POS_W-1:0]    hi_thr_reg;
    logic [POS_W-1:0]    lo_thr_reg;

    logic                in_valid_reg;
    logic [IDX_W-1:0]    axis_index_reg;
    logic [STATUS_W-1:0] drive_status_reg;
    logic [POS_W-1:0]    actual_position_reg;
    logic                last_axis_reg;

    logic                out_valid_reg;
    result_t             result_reg;

    logic                advance;
    logic                step;
    logic                in_take;
    approach_cfg_t       acfg;
    result_t             result_next;
    logic                all_on;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_position_reg   <= DEFAULT_POSITION_RST;
            approach_step_reg      <= APPROACH_STEP_RST;
            approach_tolerance_reg <= APPROACH_TOLERANCE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEFAULT_POSITION:   default_position_reg   <= cfg_data;
                CFG_APPROACH_STEP:      approach_step_reg      <= cfg_data[STEP_W-1:0];
                CFG_APPROACH_TOLERANCE: approach_tolerance_reg <= cfg_data[STEP_W-1:0];
                default:                default_position_reg   <= default_position_reg;
            endcase
        end
    end

    // home window edges, wrapping
    always_ff @(posedge clk)
    begin
        hi_thr_reg <= default_position_reg + {16'd0, approach_tolerance_reg};
        lo_thr_reg <= default_position_reg - {16'd0, approach_tolerance_reg};
    end

    assign acfg.hi_thr        = hi_thr_reg;
    assign acfg.lo_thr        = lo_thr_reg;
    assign acfg.approach_step = approach_step_reg;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            axis_index_reg      <= axis_index;
            drive_status_reg    <= drive_status;
            actual_position_reg <= actual_position;
            last_axis_reg       <= last_axis;
        end
    end

    saes_axis_core #(
        .NUM_AXES     (NUM_AXES),
        .RETRY_PERIOD (RETRY_PERIOD)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .axis_index      (axis_index_reg),
        .drive_status    (drive_status_reg),
        .actual_position (actual_position_reg),
        .last_axis       (last_axis_reg),
        .acfg            (acfg),
        .res             (result_next),
        .all_on          (all_on)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign control_word  = result_reg.control_word;
    assign control_valid = result_reg.control_valid;
    assign target_pos    = result_reg.target_pos;
    assign target_valid  = result_reg.target_valid;
    assign axis_enabled  = result_reg.axis_enabled;
    assign all_enabled   = result_reg.all_enabled;
    assign homing_done   = result_reg.homing_done;

`ifndef SYNTHESIS
    // operation mode is left only by reset
    a_all_on_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        all_on |=> all_on)
        else $error("operation mode dropped");

    // control words only in status mode and only known codes
    a_ctrl_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && control_valid) |->
            (!all_enabled && (control_word == CW_SHUTDOWN ||
             control_word == CW_SWITCH_ON || control_word == CW_ENABLE_OP)))
        else $error("bad control word");

    // stall only when both registers are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("spurious input stall");

    // a result is produced for every processed item
    a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("result lost");
`endif

endmodule

@@ tb/saes_sequence_checker.sv @@
// enable sequence checker: predicts each axis result and compares the output transfers
module saes_sequence_checker
    import saes_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [IDX_W-1:0]    axis_index,
    input  logic [STATUS_W-1:0] drive_status,
    input  logic [POS_W-1:0]    actual_position,
    input  logic                last_axis,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STATUS_W-1:0] control_word,
    input  logic                control_valid,
    input  logic [POS_W-1:0]    target_pos,
    input  logic                target_valid,
    input  logic                axis_enabled,
    input  logic                all_enabled,
    input  logic                homing_done,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [POS_W-1:0]    cfg_data,
    output int                  mismatches,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAX = NUM_AXES_DEF;
    localparam int RETRY = RETRY_PERIOD_DEF;

    logic [STATUS_W-1:0] seen_status [NAX];
    logic [2:0]          retry_left [NAX];
    logic [POS_W-1:0]    axis_goal [NAX];
    bit                  axis_homed [NAX];
    bit                  drive_on [NAX];
    bit                  op_mode;

    logic [POS_W-1:0]  home_pos;
    logic [STEP_W-1:0] step_size;
    logic [STEP_W-1:0] home_tol;

    result_t predicted_axis_results [$];
    result_t next_result;
    result_t want;
    result_t got;
    logic [6:0] bad_fields;

    task automatic step_drive_sequence(
        input  logic [IDX_W-1:0]    idx,
        input  logic [STATUS_W-1:0] sw,
        input  logic [POS_W-1:0]    pos,
        input  logic                last,
        output result_t             r
    );
        logic [7:0]       low;
        bit               in_rng;
        bit               all_on;
        logic [POS_W-1:0] upper;
        logic [POS_W-1:0] lower;
        r = '0;
        low = sw[7:0];
        in_rng = idx < NAX;
        if (!op_mode)
        begin
            if (in_rng)
            begin
                if (seen_status[idx] != sw)
                begin
                    seen_status[idx] = sw;
                    retry_left[idx] = 3'(RETRY);
                end
                if (low != ST_OP_ENABLED)
                begin
                    drive_on[idx] = 1'b0;
                    if (retry_left[idx] == RETRY)
                    begin
                        if (low == ST_SWITCH_ON_DISABLED)
                        begin
                            r.control_word = CW_SHUTDOWN;
                            r.control_valid = 1'b1;
                        end
                        else if (low == ST_READY_ALT || low == ST_READY_TO_SWITCH_ON ||
                                 low == ST_SWITCHED_ON)
                        begin
                            axis_goal[idx] = pos;
                            r.target_pos = pos;
                            r.target_valid = 1'b1;
                            r.control_word = (low == ST_SWITCHED_ON) ? CW_ENABLE_OP
                                                                     : CW_SWITCH_ON;
                            r.control_valid = 1'b1;
                        end
                    end
                    if (retry_left[idx] == 0)
                        retry_left[idx] = 3'(RETRY);
                    else
                        retry_left[idx] = retry_left[idx] - 3'd1;
                end
                else
                    drive_on[idx] = 1'b1;
            end
            if (last)
            begin
                all_on = 1'b1;
                for (int k = 0; k < NAX; k++)
                    all_on = all_on && drive_on[k];
                op_mode = all_on;
            end
        end
        else if (in_rng && low == ST_OP_ENABLED && !axis_homed[idx])
        begin
            // thresholds wrap modulo 2^32, then compare signed
            upper = home_pos + {16'd0, home_tol};
            lower = home_pos - {16'd0, home_tol};
            if ($signed(pos) > $signed(upper))
                axis_goal[idx] = axis_goal[idx] - {16'd0, step_size};
            else if ($signed(pos) < $signed(lower))
                axis_goal[idx] = axis_goal[idx] + {16'd0, step_size};
            else
                axis_homed[idx] = 1'b1;
            r.target_pos = axis_goal[idx];
            r.target_valid = 1'b1;
        end
        if (in_rng)
            r.homing_done = axis_homed[idx];
        r.axis_enabled = in_rng && low == ST_OP_ENABLED;
        r.all_enabled = op_mode;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NAX; k++)
            begin
                seen_status[k] = '0;
                retry_left[k] = 3'(RETRY);
                axis_goal[k] = '0;
                axis_homed[k] = 1'b0;
                drive_on[k] = 1'b0;
            end
            op_mode = 1'b0;
            home_pos = DEFAULT_POSITION_RST;
            step_size = APPROACH_STEP_RST;
            home_tol = APPROACH_TOLERANCE_RST;
            predicted_axis_results.delete();
            mismatches = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DEFAULT_POSITION:   home_pos = cfg_data;
                    CFG_APPROACH_STEP:      step_size = cfg_data[STEP_W-1:0];
                    CFG_APPROACH_TOLERANCE: home_tol = cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                got.control_word = control_word;
                got.control_valid = control_valid;
                got.target_pos = target_pos;
                got.target_valid = target_valid;
                got.axis_enabled = axis_enabled;
                got.all_enabled = all_enabled;
                got.homing_done = homing_done;
                if (predicted_axis_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: output transfer with no result pending: %p", $time, got);
                end
                else
                begin
                    want = predicted_axis_results.pop_front();
                    bad_fields = {want.control_word !== got.control_word,
                                  want.control_valid !== got.control_valid,
                                  want.target_pos !== got.target_pos,
                                  want.target_valid !== got.target_valid,
                                  want.axis_enabled !== got.axis_enabled,
                                  want.all_enabled !== got.all_enabled,
                                  want.homing_done !== got.homing_done};
                    if (bad_fields != 0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result mismatch, fields cw/cv/tp/tv/en/all/hd = %b",
                                     $time, bad_fields);
                            $display("  expected cw=%h cv=%b tp=%h tv=%b en=%b all=%b hd=%b",
                                     want.control_word, want.control_valid,
                                     want.target_pos, want.target_valid,
                                     want.axis_enabled, want.all_enabled, want.homing_done);
                            $display("  actual   cw=%h cv=%b tp=%h tv=%b en=%b all=%b hd=%b",
                                     got.control_word, got.control_valid,
                                     got.target_pos, got.target_valid,
                                     got.axis_enabled, got.all_enabled, got.homing_done);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                step_drive_sequence(axis_index, drive_status, actual_position, last_axis,
                                    next_result);
                predicted_axis_results.push_back(next_result);
            end
            pending <= predicted_axis_results.size();
        end
    end

endmodule

@@ tb/tb_servo_axis_enable_sequencer.sv @@
// testbench top: stimulus, receiver stalls and verdict for the enable sequencer
module tb_servo_axis_enable_sequencer;
    timeunit 1ns;
    timeprecision 1ps;
    import saes_pkg::*;

    localparam int NAX = NUM_AXES_DEF;
    localparam int NO_AXIS = 7;
    localparam logic [1:0] CFG_NONE = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [IDX_W-1:0]    axis_index;
    logic [STATUS_W-1:0] drive_status;
    logic [POS_W-1:0]    actual_position;
    logic                last_axis;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] control_word;
    logic                control_valid;
    logic [POS_W-1:0]    target_pos;
    logic                target_valid;
    logic                axis_enabled;
    logic                all_enabled;
    logic                homing_done;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [POS_W-1:0]    cfg_data;

    int mismatches;
    int pending;

    bit in_gaps;
    bit out_gaps;
    bit hold_req;

    logic [STATUS_W-1:0] axis_word [NAX];
    int                  word_hold [NAX];
    bit                  shadow_on [NAX];
    logic [POS_W-1:0]    home_now;
    logic [STEP_W-1:0]   tol_now;

    servo_axis_enable_sequencer uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .axis_index      (axis_index),
        .drive_status    (drive_status),
        .actual_position (actual_position),
        .last_axis       (last_axis),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .control_word    (control_word),
        .control_valid   (control_valid),
        .target_pos      (target_pos),
        .target_valid    (target_valid),
        .axis_enabled    (axis_enabled),
        .all_enabled     (all_enabled),
        .homing_done     (homing_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    saes_sequence_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .axis_index      (axis_index),
        .drive_status    (drive_status),
        .actual_position (actual_position),
        .last_axis       (last_axis),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .control_word    (control_word),
        .control_valid   (control_valid),
        .target_pos      (target_pos),
        .target_valid    (target_valid),
        .axis_enabled    (axis_enabled),
        .all_enabled     (all_enabled),
        .homing_done     (homing_done),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (90) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (out_gaps && $urandom_range(0, 6) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [POS_W-1:0] any_position();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 32'h7FFF_FFFF;
        else if (pick == 1)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] approach_position();
        int pick;
        logic [POS_W-1:0] off;
        pick = $urandom_range(0, 59);
        if (pick == 0)
        begin
            // close to home, a couple of counts past the band on either side
            off = $urandom_range(0, 2 * tol_now + 4);
            return home_now + off - ({16'd0, tol_now} + 32'd2);
        end
        else if (pick == 1)
            return home_now + {16'd0, tol_now} + 32'd1;
        else if (pick == 2)
            return home_now - {16'd0, tol_now} - 32'd1;
        return any_position();
    endfunction

    task automatic send_item(
        input logic [IDX_W-1:0]    idx,
        input logic [STATUS_W-1:0] w,
        input logic [POS_W-1:0]    pos,
        input logic                last
    );
        if (in_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        axis_index <= idx;
        drive_status <= w;
        actual_position <= pos;
        last_axis <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // guard keeps status mode alive: a cycle end that would see every axis on is dropped
    task automatic offer(
        input int                  idx,
        input logic [STATUS_W-1:0] w,
        input logic [POS_W-1:0]    pos,
        input bit                  last,
        input bit                  guard
    );
        bit all_on;
        bit end_cycle;
        end_cycle = last;
        if (guard && last)
        begin
            all_on = 1'b1;
            for (int k = 0; k < NAX; k++)
                all_on = all_on && ((k == idx) ? (w[7:0] == ST_OP_ENABLED) : shadow_on[k]);
            if (all_on)
                end_cycle = 1'b0;
        end
        if (idx < NAX)
            shadow_on[idx] = (w[7:0] == ST_OP_ENABLED);
        send_item(idx[IDX_W-1:0], w, pos, end_cycle);
    endtask

    task automatic next_drive_word(input int a, output logic [STATUS_W-1:0] w);
        logic [7:0] hb;
        logic [7:0] lb;
        int pick;
        if (word_hold[a] > 0)
            word_hold[a]--;
        else
        begin
            pick = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0)
                hb = 8'($urandom_range(0, 255));
            else
                hb = axis_word[a][15:8];
            case (pick)
                0, 1:    lb = ST_SWITCH_ON_DISABLED;
                2:       lb = ST_READY_TO_SWITCH_ON;
                3:       lb = ST_READY_ALT;
                4, 5:    lb = ST_SWITCHED_ON;
                6, 7:    lb = ST_OP_ENABLED;
                default: lb = 8'($urandom_range(0, 255));
            endcase
            axis_word[a] = {hb, lb};
            word_hold[a] = $urandom_range(0, 13);
        end
        w = axis_word[a];
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] ridx, input logic [POS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= ridx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic apply_settings(
        input logic [POS_W-1:0]  home,
        input logic [STEP_W-1:0] stp,
        input logic [STEP_W-1:0] tol,
        input bit                with_unused
    );
        logic [15:0] junk;
        in_valid <= 1'b0;
        wait_idle();
        junk = 16'($urandom_range(0, 65535));
        write_reg(CFG_DEFAULT_POSITION, home);
        write_reg(CFG_APPROACH_STEP, {junk, stp});
        junk = 16'($urandom_range(0, 65535));
        write_reg(CFG_APPROACH_TOLERANCE, {junk, tol});
        if (with_unused)
            write_reg(CFG_NONE, $urandom);
        cfg_valid <= 1'b0;
        home_now = home;
        tol_now = tol;
    endtask

    task automatic run_approach(input int n);
        logic [7:0] hb;
        logic [STATUS_W-1:0] w;
        for (int i = 0; i < n; i++)
        begin
            hb = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 6) != 0)
                w = {hb, ST_OP_ENABLED};
            else
                w = 16'($urandom_range(0, 65535));
            offer($urandom_range(0, NO_AXIS), w, approach_position(),
                  $urandom_range(0, 6) == 0, 1'b0);
        end
    endtask

    initial
    begin
        int sent;
        int rot;
        int a;
        bit hold_done;
        logic [7:0] hb;
        logic [STATUS_W-1:0] w;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        axis_index <= '0;
        drive_status <= '0;
        actual_position <= '0;
        last_axis <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_gaps = 1'b1;
        out_gaps = 1'b1;
        hold_req = 1'b0;
        hold_done = 1'b0;
        for (int k = 0; k < NAX; k++)
        begin
            axis_word[k] = '0;
            word_hold[k] = 0;
            shadow_on[k] = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apply_settings($urandom, 16'($urandom_range(1, 65535)),
                       16'($urandom_range(0, 65535)), 1'b1);

        // status mode corners: unknown state, retry period, each drive state, stray axis
        offer(0, 16'h0000, any_position(), 1'b0, 1'b1);
        offer(0, {8'h00, ST_SWITCH_ON_DISABLED}, any_position(), 1'b0, 1'b1);
        repeat (6) offer(0, {8'h00, ST_SWITCH_ON_DISABLED}, any_position(), 1'b0, 1'b1);
        offer(1, {8'h00, ST_READY_TO_SWITCH_ON}, 32'h7FFF_FFFF, 1'b0, 1'b1);
        offer(2, {8'h00, ST_READY_ALT}, 32'h8000_0000, 1'b0, 1'b1);
        offer(3, {8'hFF, ST_SWITCHED_ON}, 32'hFFFF_FFFF, 1'b0, 1'b1);
        offer(4, {8'h00, ST_OP_ENABLED}, 32'h0000_0000, 1'b0, 1'b1);
        offer(NO_AXIS, {8'h00, ST_SWITCH_ON_DISABLED}, any_position(), 1'b1, 1'b1);
        offer(5, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b1);

        // status mode: bus cycles of drives working through their states, plus noise
        sent = 0;
        while (sent < 700)
        begin
            if (sent >= 300 && !hold_done)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                in_gaps = $urandom_range(0, 2) != 0;
                out_gaps = $urandom_range(0, 2) != 0;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                offer($urandom_range(0, NO_AXIS), 16'($urandom_range(0, 65535)),
                      any_position(), 1'($urandom_range(0, 1)), 1'b1);
                sent++;
            end
            else
            begin
                rot = $urandom_range(0, NAX - 1);
                for (int k = 0; k < NAX; k++)
                begin
                    a = (k + rot) % NAX;
                    next_drive_word(a, w);
                    offer(a, w, any_position(), k == NAX - 1, 1'b1);
                    sent++;
                end
            end
        end

        // every axis enabled within one bus cycle
        for (int k = 0; k < NAX; k++)
        begin
            hb = 8'($urandom_range(0, 255));
            if (k == 3)
                offer(NO_AXIS, {hb, ST_SWITCH_ON_DISABLED}, any_position(), 1'b0, 1'b0);
            offer(k, {hb, ST_OP_ENABLED}, any_position(), k == NAX - 1, 1'b0);
        end

        // approach band edges at reset values
        apply_settings(DEFAULT_POSITION_RST, APPROACH_STEP_RST, APPROACH_TOLERANCE_RST, 1'b0);
        offer(0, {8'h00, ST_OP_ENABLED}, 32'd80, 1'b0, 1'b0);
        offer(1, {8'h00, ST_OP_ENABLED}, 32'd81, 1'b0, 1'b0);
        offer(1, {8'h00, ST_OP_ENABLED}, 32'hFFFF_FFAF, 1'b0, 1'b0);
        offer(2, {8'h00, ST_OP_ENABLED}, 32'hFFFF_FFB0, 1'b0, 1'b0);
        offer(3, {8'hFF, ST_SWITCH_ON_DISABLED}, any_position(), 1'b0, 1'b0);
        offer(NO_AXIS, {8'h00, ST_OP_ENABLED}, 32'd0, 1'b1, 1'b0);
        offer(0, {8'h00, ST_OP_ENABLED}, 32'd1000, 1'b0, 1'b0);

        // operation mode under several settings, extremes included
        apply_settings(32'h7FFF_FFF0, 16'hFFFF, 16'hFFFF, 1'b0);
        run_approach(125);
        apply_settings(32'h8000_0005, 16'd1, 16'd0, 1'b0);
        in_gaps = 1'b0;
        out_gaps = 1'b1;
        run_approach(125);
        apply_settings($urandom, 16'($urandom_range(1, 65535)),
                       16'($urandom_range(0, 65535)), 1'b1);
        in_gaps = 1'b1;
        out_gaps = 1'b1;
        run_approach(125);
        apply_settings($urandom, 16'hFFFF, 16'd0, 1'b0);
        in_gaps = 1'b1;
        out_gaps = 1'b0;
        run_approach(125);
        apply_settings($urandom, 16'($urandom_range(1, 65535)),
                       16'($urandom_range(0, 300)), 1'b0);
        in_gaps = 1'b0;
        out_gaps = 1'b0;
        run_approach(125);

        in_valid <= 1'b0;
        wait_idle();
        repeat (12) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
